// ----- design/updc_pkg.sv -----
// Package for the URL path percent-decode checker: beat types, character
// constants, escape and error codes, and the hex digit decoder.
// No dependencies; every other design file uses it by scoped names.
package updc_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_QUERY   = 8'h3F;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LC_A    = 8'h61;
	localparam logic [7:0] CH_UC_A    = 8'h41;

	// Progress through a "%HH" escape.
	typedef enum logic [1:0] {
		ESC_NONE   = 2'd0,
		ESC_HI     = 2'd1,
		ESC_LO     = 2'd2,
		ESC_LO_BAD = 2'd3
	} esc_t;

	// First decode error seen in the request.
	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_TRUNC   = 2'd1,
		ERR_BAD_HEX = 2'd2,
		ERR_SLASH   = 2'd3
	} err_t;

	// Status reported with the final beat of a request.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TRUNC     = 3'd1,
		ST_BAD_HEX   = 3'd2,
		ST_SLASH     = 3'd3,
		ST_TRAVERSAL = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       in_query;
		logic       done_res;
		logic [2:0] status;
	} rsp_t;

	// Returns {digit_ok, value}; value is zero when the character is not hex.
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= CH_ZERO && b <= CH_ZERO + 8'd9) begin
			r = {1'b1, 4'(b - CH_ZERO)};
		end else if (b >= CH_LC_A && b <= CH_LC_A + 8'd5) begin
			r = {1'b1, 4'(b - CH_LC_A + 8'd10)};
		end else if (b >= CH_UC_A && b <= CH_UC_A + 8'd5) begin
			r = {1'b1, 4'(b - CH_UC_A + 8'd10)};
		end
		return r;
	endfunction

endpackage

// ----- design/url_path_percent_decode_check_top.sv -----
// A byte is held in the input register; its result beat is registered in the result
// register, which drives rsp. Throughput: one byte per cycle, sustained while rsp is
// not stalled; each register holds one beat, so while a result waits one more byte
// can still enter the input register. All decode work sits between the two.
// Reset (arst_n low, asynchronous) empties both registers and clears the decoder
// state to the start of a new request; the block is ready right after reset.
module url_path_percent_decode_check_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  updc_pkg::req_t  req_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output updc_pkg::rsp_t  rsp_data
);

	// Input register: one raw byte waiting to be decoded.
	logic           valid_s1;
	updc_pkg::req_t req_s1;

	// Result register.
	logic           rsp_valid_q;
	updc_pkg::rsp_t rsp_q;

	// Decoder state carried across the bytes of one request.
	logic           query_q;
	updc_pkg::esc_t esc_q;
	logic [3:0]     hi_nib_q;
	logic [1:0]     seg_len_q;
	logic           seg_dots_q;
	updc_pkg::err_t err_q;
	logic           trav_q;

	// Next-state values and the result computed from the byte in the input register.
	logic           query_n;
	updc_pkg::esc_t esc_n;
	logic [3:0]     hi_nib_n;
	logic [1:0]     seg_len_n;
	logic           seg_dots_n;
	updc_pkg::err_t err_n;
	logic           trav_n;
	logic           emit;
	logic [7:0]     emit_byte;
	logic           emit_query;
	logic [2:0]     status;
	logic [4:0]     hex;
	logic [7:0]     decoded;
	logic           advance;

	// The byte in the input register moves on whenever the result register is
	// free or is being emptied in this cycle. Bytes that make no result move on
	// too, so they never hold the pipe.
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	assign hex     = updc_pkg::hex_digit(req_s1.in_byte);
	assign decoded = {hi_nib_q, hex[3:0]};

	// One decode step, following the order of checks of the decoder: query
	// pass-through, the '?' that ends the path, the two digits of an escape,
	// the '%' that opens one, a literal slash, and any other path byte.
	always_comb begin
		query_n    = query_q;
		esc_n      = esc_q;
		hi_nib_n   = hi_nib_q;
		seg_len_n  = seg_len_q;
		seg_dots_n = seg_dots_q;
		err_n      = err_q;
		trav_n     = trav_q;
		emit       = 1'b0;
		emit_byte  = 8'd0;
		emit_query = 1'b0;
		status     = updc_pkg::ST_OK;

		if (err_q == updc_pkg::ERR_NONE) begin
			if (query_q) begin
				emit       = 1'b1;
				emit_byte  = req_s1.in_byte;
				emit_query = 1'b1;
			end else if (req_s1.in_byte == updc_pkg::CH_QUERY) begin
				if (esc_q != updc_pkg::ESC_NONE) begin
					// An escape cut short by the start of the query.
					err_n = updc_pkg::ERR_TRUNC;
					esc_n = updc_pkg::ESC_NONE;
				end else begin
					if (seg_len_n == 2'd2 && seg_dots_n) begin
						trav_n = 1'b1;
					end
					seg_len_n  = 2'd0;
					seg_dots_n = 1'b1;
					query_n    = 1'b1;
					emit       = 1'b1;
					emit_byte  = req_s1.in_byte;
					emit_query = 1'b1;
				end
			end else if (esc_q == updc_pkg::ESC_HI) begin
				// A bad first digit is only reported once the second arrives.
				if (!hex[4]) begin
					esc_n = updc_pkg::ESC_LO_BAD;
				end else begin
					hi_nib_n = hex[3:0];
					esc_n    = updc_pkg::ESC_LO;
				end
			end else if (esc_q == updc_pkg::ESC_LO || esc_q == updc_pkg::ESC_LO_BAD) begin
				if (esc_q == updc_pkg::ESC_LO_BAD || !hex[4]) begin
					err_n = updc_pkg::ERR_BAD_HEX;
				end else if (decoded == updc_pkg::CH_SLASH) begin
					err_n = updc_pkg::ERR_SLASH;
				end else begin
					emit      = 1'b1;
					emit_byte = decoded;
					if (seg_len_n != 2'd3) begin
						seg_len_n = seg_len_n + 2'd1;
					end
					if (decoded != updc_pkg::CH_DOT) begin
						seg_dots_n = 1'b0;
					end
				end
				esc_n = updc_pkg::ESC_NONE;
			end else if (req_s1.in_byte == updc_pkg::CH_PERCENT) begin
				esc_n = updc_pkg::ESC_HI;
			end else if (req_s1.in_byte == updc_pkg::CH_SLASH) begin
				if (seg_len_n == 2'd2 && seg_dots_n) begin
					trav_n = 1'b1;
				end
				seg_len_n  = 2'd0;
				seg_dots_n = 1'b1;
				emit       = 1'b1;
				emit_byte  = req_s1.in_byte;
			end else begin
				emit      = 1'b1;
				emit_byte = req_s1.in_byte;
				if (seg_len_n != 2'd3) begin
					seg_len_n = seg_len_n + 2'd1;
				end
				if (req_s1.in_byte != updc_pkg::CH_DOT) begin
					seg_dots_n = 1'b0;
				end
			end
		end

		// The final byte closes the last path segment, or flags an escape that
		// never finished, and picks the status; decode errors outrank traversal.
		if (req_s1.is_last) begin
			if (err_n == updc_pkg::ERR_NONE && !query_n) begin
				if (esc_n != updc_pkg::ESC_NONE) begin
					err_n = updc_pkg::ERR_TRUNC;
				end else if (seg_len_n == 2'd2 && seg_dots_n) begin
					trav_n = 1'b1;
				end
			end
			case (err_n)
				updc_pkg::ERR_TRUNC:   status = updc_pkg::ST_TRUNC;
				updc_pkg::ERR_BAD_HEX: status = updc_pkg::ST_BAD_HEX;
				updc_pkg::ERR_SLASH:   status = updc_pkg::ST_SLASH;
				default:               status = trav_n ? updc_pkg::ST_TRAVERSAL
				                                       : updc_pkg::ST_OK;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!valid_s1 || advance) begin
			req_s1 <= req_data;
		end
	end

	// Decoder state. After the final byte of a request everything returns to
	// its reset value, so the next byte starts a fresh request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q    <= 1'b0;
			esc_q      <= updc_pkg::ESC_NONE;
			hi_nib_q   <= 4'd0;
			seg_len_q  <= 2'd0;
			seg_dots_q <= 1'b1;
			err_q      <= updc_pkg::ERR_NONE;
			trav_q     <= 1'b0;
		end else if (advance) begin
			if (req_s1.is_last) begin
				query_q    <= 1'b0;
				esc_q      <= updc_pkg::ESC_NONE;
				hi_nib_q   <= 4'd0;
				seg_len_q  <= 2'd0;
				seg_dots_q <= 1'b1;
				err_q      <= updc_pkg::ERR_NONE;
				trav_q     <= 1'b0;
			end else begin
				query_q    <= query_n;
				esc_q      <= esc_n;
				hi_nib_q   <= hi_nib_n;
				seg_len_q  <= seg_len_n;
				seg_dots_q <= seg_dots_n;
				err_q      <= err_n;
				trav_q     <= trav_n;
			end
		end
	end

	// Result register. A byte that makes no result leaves it empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= emit || req_s1.is_last;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.out_byte   <= emit_byte;
			rsp_q.byte_valid <= emit;
			rsp_q.in_query   <= emit_query;
			rsp_q.done_res   <= req_s1.is_last;
			rsp_q.status     <= status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ----- design/updc_checker.sv -----
// Port-level checks for the URL path percent-decode checker, and the bind that
// attaches them to url_path_percent_decode_check_top. Uses updc_pkg.
module updc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input updc_pkg::req_t req_data,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input updc_pkg::rsp_t rsp_data
);

	// A stalled request beat stays offered and unchanged.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req_data))
		else $error("request beat changed while stalled");

	// A stalled result beat stays offered and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("result beat changed while stalled");

	// A beat carries either a produced byte or the end of the request.
	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.byte_valid |-> rsp_data.done_res)
		else $error("result beat with neither a byte nor the end mark");

	// Without a produced byte the byte and query mark are zero.
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.byte_valid
			|-> rsp_data.out_byte == 8'd0 && !rsp_data.in_query)
		else $error("byte fields set on a beat without a byte");

	// Status is only reported on the final beat of a request.
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.done_res |-> rsp_data.status == updc_pkg::ST_OK)
		else $error("status set before the end of the request");

endmodule

bind url_path_percent_decode_check_top updc_checker u_updc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_data  (req_data),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);

// ----- sim/updc_decode_checker.sv -----
`timescale 1ns / 100ps
// Checker for the URL path percent-decode block: it follows both channels,
// predicts the result beat of every accepted byte and compares the results in order.
// Depends on updc_pkg for the beat types, the character constants and the codes.
module updc_decode_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  updc_pkg::req_t req_data,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  updc_pkg::rsp_t rsp_data,
	output int             fail_count,
	output int             pending
);

	// Decoder state as the block should hold it between bytes.
	logic           query_part;
	updc_pkg::esc_t esc;
	logic [3:0]     hi_nibble;
	logic [1:0]     seg_len;
	logic           seg_dots;
	updc_pkg::err_t err;
	logic           dotdot_seen;

	updc_pkg::rsp_t expected_beats[$];

	function automatic void clear_request();
		query_part  = 1'b0;
		esc         = updc_pkg::ESC_NONE;
		hi_nibble   = 4'd0;
		seg_len     = 2'd0;
		seg_dots    = 1'b1;
		err         = updc_pkg::ERR_NONE;
		dotdot_seen = 1'b0;
	endfunction

	function automatic void end_segment();
		if (seg_len == 2'd2 && seg_dots) begin
			dotdot_seen = 1'b1;
		end
		seg_len  = 2'd0;
		seg_dots = 1'b1;
	endfunction

	function automatic void add_to_segment(input logic [7:0] c);
		if (seg_len != 2'd3) begin
			seg_len++;
		end
		if (c != updc_pkg::CH_DOT) begin
			seg_dots = 1'b0;
		end
	endfunction

	// Returns {is_hex, value}.
	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= updc_pkg::CH_ZERO && c <= updc_pkg::CH_ZERO + 8'd9) begin
			d = c - updc_pkg::CH_ZERO;
		end else if (c >= updc_pkg::CH_LC_A && c <= updc_pkg::CH_LC_A + 8'd5) begin
			d = c - updc_pkg::CH_LC_A + 8'd10;
		end else if (c >= updc_pkg::CH_UC_A && c <= updc_pkg::CH_UC_A + 8'd5) begin
			d = c - updc_pkg::CH_UC_A + 8'd10;
		end else begin
			return 5'd0;
		end
		return {1'b1, d[3:0]};
	endfunction

	task automatic decode_byte(input updc_pkg::req_t r, output logic produce,
			output updc_pkg::rsp_t e);
		logic [7:0]        b;
		logic [4:0]        h;
		logic              emit;
		logic [7:0]        ob;
		logic              q;
		updc_pkg::status_t st;
		b    = r.in_byte;
		emit = 1'b0;
		ob   = 8'd0;
		q    = 1'b0;
		st   = updc_pkg::ST_OK;
		// Once an error is recorded, nothing but the end of the request matters.
		if (err == updc_pkg::ERR_NONE) begin
			if (query_part) begin
				emit = 1'b1;
				ob   = b;
				q    = 1'b1;
			end else if (b == updc_pkg::CH_QUERY) begin
				if (esc != updc_pkg::ESC_NONE) begin
					err = updc_pkg::ERR_TRUNC;
					esc = updc_pkg::ESC_NONE;
				end else begin
					end_segment();
					query_part = 1'b1;
					emit       = 1'b1;
					ob         = b;
					q          = 1'b1;
				end
			end else if (esc == updc_pkg::ESC_HI) begin
				h = hex_of(b);
				if (h[4]) begin
					hi_nibble = h[3:0];
					esc       = updc_pkg::ESC_LO;
				end else begin
					esc = updc_pkg::ESC_LO_BAD;
				end
			end else if (esc != updc_pkg::ESC_NONE) begin
				h = hex_of(b);
				if (esc == updc_pkg::ESC_LO_BAD || !h[4]) begin
					err = updc_pkg::ERR_BAD_HEX;
				end else if ({hi_nibble, h[3:0]} == updc_pkg::CH_SLASH) begin
					err = updc_pkg::ERR_SLASH;
				end else begin
					emit = 1'b1;
					ob   = {hi_nibble, h[3:0]};
					add_to_segment(ob);
				end
				esc = updc_pkg::ESC_NONE;
			end else if (b == updc_pkg::CH_PERCENT) begin
				esc = updc_pkg::ESC_HI;
			end else if (b == updc_pkg::CH_SLASH) begin
				end_segment();
				emit = 1'b1;
				ob   = b;
			end else begin
				emit = 1'b1;
				ob   = b;
				add_to_segment(b);
			end
		end
		if (r.is_last) begin
			if (err == updc_pkg::ERR_NONE && !query_part) begin
				if (esc != updc_pkg::ESC_NONE) begin
					err = updc_pkg::ERR_TRUNC;
				end else begin
					end_segment();
				end
			end
			case (err)
				updc_pkg::ERR_TRUNC:   st = updc_pkg::ST_TRUNC;
				updc_pkg::ERR_BAD_HEX: st = updc_pkg::ST_BAD_HEX;
				updc_pkg::ERR_SLASH:   st = updc_pkg::ST_SLASH;
				default:               st = dotdot_seen ? updc_pkg::ST_TRAVERSAL
				                                        : updc_pkg::ST_OK;
			endcase
		end
		produce      = emit | r.is_last;
		e.out_byte   = ob;
		e.byte_valid = emit;
		e.in_query   = q;
		e.done_res   = r.is_last;
		e.status     = st;
		if (r.is_last) begin
			clear_request();
		end
	endtask

	task automatic check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	// Results are compared before the byte of the same edge is predicted: the block
	// registers each byte first, so a result never belongs to a byte of its own edge.
	always @(posedge clk or negedge arst_n) begin
		updc_pkg::rsp_t want;
		updc_pkg::rsp_t guess;
		logic           produce;
		if (!arst_n) begin
			clear_request();
			expected_beats.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: result beat expected none, got %h", $time, rsp_data);
					fail_count++;
				end else begin
					want = expected_beats.pop_front();
					check_field("out_byte", want.out_byte, rsp_data.out_byte);
					check_field("byte_valid", 8'(want.byte_valid),
						8'(rsp_data.byte_valid));
					check_field("in_query", 8'(want.in_query), 8'(rsp_data.in_query));
					check_field("done_res", 8'(want.done_res), 8'(rsp_data.done_res));
					check_field("status", 8'(want.status), 8'(rsp_data.status));
				end
			end
			if (req_valid && !req_stall) begin
				decode_byte(req_data, produce, guess);
				if (produce) begin
					expected_beats.insert(expected_beats.size(), guess);
				end
			end
			pending = expected_beats.size();
		end
	end

endmodule

// ----- sim/url_path_percent_decode_check_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for url_path_percent_decode_check_top: drives request strings
// byte by byte under changing idle patterns and gives the verdict.
// Depends on updc_pkg, the block itself and the updc_decode_checker module.
module url_path_percent_decode_check_top_tb;

	// The limit leaves a wide margin on top of the slowest correct run.
	localparam int CYCLE_LIMIT  = 200000;
	// Random bytes that reach the decoder, at least, in each of three idle patterns.
	localparam int PHASE_BYTES  = 270;
	// Length of the single long stall on the result side.
	localparam int LONG_HOLD    = 150;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	updc_pkg::req_t req_data;
	logic           rsp_valid;
	logic           rsp_stall;
	updc_pkg::rsp_t rsp_data;

	int   fail_count;
	int   pending;
	int   cycle_count;
	int   send_idle_pct;
	int   recv_idle_pct;
	logic long_hold_req;

	// The request string being sent, one character per beat.
	logic [7:0] req_text[$];

	url_path_percent_decode_check_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	updc_decode_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The result side stalls at random with the current idle percentage. The
	// first time the long hold is requested it stalls for a long stretch in one
	// go, so the two registers in the block fill up and the block has to stall
	// the request side while bytes keep being offered.
	initial begin : receiver
		bit held;
		int hold_left;
		held      = 1'b0;
		hold_left = 0;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req && !held) begin
				held      = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Watchdog: a hang or a lost result ends the run here.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Offers one beat and returns at the edge that takes it. Idle cycles come
	// first and never depend on the stall. The stall is sampled at the falling
	// edge, where it has settled, so the check does not race the block.
	task automatic send_beat(input logic [7:0] b, input logic last);
		logic stalled;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= {b, last};
		do begin
			@(negedge clk);
			stalled = req_stall;
			@(posedge clk);
		end while (stalled);
	endtask

	task automatic send_request();
		for (int i = 0; i < req_text.size(); i++) begin
			send_beat(req_text[i], i == req_text.size() - 1);
		end
	endtask

	// Lowers valid, waits until every expected result has come back and then
	// switches to the next idle pattern. Called at a rising edge, returns at one.
	task automatic drain_and_set(input int send_pct, input int recv_pct, input logic hold);
		req_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (pending != 0);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		long_hold_req = hold;
		@(posedge clk);
	endtask

	// Appends one character to the request string.
	task automatic add_char(input logic [7:0] c);
		req_text.insert(req_text.size(), c);
	endtask

	task automatic load_text(input string s);
		req_text.delete();
		for (int i = 0; i < s.len(); i++) begin
			add_char(s[i]);
		end
	endtask

	// Any character except the three that steer the decoder.
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(255));
		end while (c == updc_pkg::CH_PERCENT || c == updc_pkg::CH_SLASH ||
			c == updc_pkg::CH_QUERY);
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return updc_pkg::CH_ZERO + {4'd0, n};
		end
		return ($urandom_range(1) ? updc_pkg::CH_LC_A : updc_pkg::CH_UC_A) +
			{4'd0, n - 4'd10};
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(255));
		end while ((c >= updc_pkg::CH_ZERO && c <= updc_pkg::CH_ZERO + 8'd9) ||
			((c | 8'h20) >= updc_pkg::CH_LC_A &&
			(c | 8'h20) <= updc_pkg::CH_LC_A + 8'd5));
		return c;
	endfunction

	task automatic push_escape(input logic [7:0] v);
		add_char(updc_pkg::CH_PERCENT);
		add_char(hex_char(v[7:4]));
		add_char(hex_char(v[3:0]));
	endtask

	// Builds a random request in req_text. Most are well formed: segments of
	// plain characters and escapes, dot segments written literally or encoded,
	// empty segments and an optional query of arbitrary bytes. Some are plain
	// noise, and some are cut at a random spot and end in a broken escape.
	// useful counts the bytes that reach the decoder before any error.
	task automatic build_random_request(output int useful);
		int         nseg;
		int         n;
		int         spot;
		logic [7:0] v;
		req_text.delete();
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(1, 8);
			repeat (n) add_char(8'($urandom_range(255)));
			useful = n;
			return;
		end
		if ($urandom_range(3) != 0) begin
			add_char(updc_pkg::CH_SLASH);
		end
		nseg = $urandom_range(1, 4);
		for (int s = 0; s < nseg; s++) begin
			if (s != 0) begin
				add_char(updc_pkg::CH_SLASH);
			end
			case ($urandom_range(7))
				0: begin
					add_char(updc_pkg::CH_DOT);
					add_char(updc_pkg::CH_DOT);
				end
				1: add_char(updc_pkg::CH_DOT);
				2: repeat (3) add_char(updc_pkg::CH_DOT);
				3: begin
					// A dot pair with at least one dot encoded.
					push_escape(updc_pkg::CH_DOT);
					if ($urandom_range(1)) begin
						push_escape(updc_pkg::CH_DOT);
					end else begin
						add_char(updc_pkg::CH_DOT);
					end
				end
				4: ;
				default: begin
					n = $urandom_range(1, 5);
					repeat (n) begin
						if ($urandom_range(3) == 0) begin
							v = 8'($urandom_range(255));
							if (v == updc_pkg::CH_SLASH) begin
								v = updc_pkg::CH_DOT;
							end
							push_escape(v);
						end else begin
							add_char(plain_char());
						end
					end
				end
			endcase
		end
		if ($urandom_range(4) < 3) begin
			add_char(updc_pkg::CH_QUERY);
			n = $urandom_range(0, 6);
			repeat (n) add_char(8'($urandom_range(255)));
		end
		useful = req_text.size();
		if ($urandom_range(4) == 0) begin
			spot = $urandom_range(req_text.size());
			while (req_text.size() > spot) void'(req_text.pop_back());
			add_char(updc_pkg::CH_PERCENT);
			case ($urandom_range(5))
				0: ;
				1: begin
					add_char(hex_char(4'($urandom_range(15))));
					add_char(updc_pkg::CH_QUERY);
				end
				2: begin
					add_char(non_hex_char());
					add_char(hex_char(4'($urandom_range(15))));
				end
				3: begin
					add_char(hex_char(4'($urandom_range(15))));
					add_char(non_hex_char());
				end
				4: begin
					add_char(hex_char(updc_pkg::CH_SLASH[7:4]));
					add_char(hex_char(updc_pkg::CH_SLASH[3:0]));
				end
				default: begin
					add_char(non_hex_char());
					add_char(updc_pkg::CH_QUERY);
				end
			endcase
			useful = req_text.size();
			// Up to two bytes after the error, which the block must swallow.
			if (req_text.size() > spot + 1) begin
				n = $urandom_range(0, 2);
				repeat (n) add_char(8'($urandom_range(255)));
			end
		end
		if (req_text.size() == 0) begin
			add_char(plain_char());
			useful = 1;
		end
	endtask

	task automatic random_phase();
		int sent;
		int useful;
		sent = 0;
		while (sent < PHASE_BYTES) begin
			build_random_request(useful);
			send_request();
			sent += useful;
		end
	endtask

	initial begin : stimulus
		// Directed requests: traversal bounded by the end, an encoded slash with
		// a byte swallowed after it, bad hex in the first and in the second
		// digit, a bad first digit cut short by the query mark, a good first
		// digit cut short by the query mark, a lone percent cut by the end, and
		// a mixed-case escape followed by a query holding the extreme bytes.
		string directed_cases[7];
		directed_cases = '{"/..", "%2fa", "%G1", "%4z", "%g?", "%4?", "%"};

		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req_data      = '0;
		send_idle_pct = 32;
		recv_idle_pct = 65;
		long_hold_req = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_cases[i]) begin
			load_text(directed_cases[i]);
			send_request();
		end
		load_text("%aF?");
		add_char(8'hFF);
		add_char(8'h00);
		send_request();

		// Sender idles less than the receiver; the long result stall comes here.
		drain_and_set(32, 65, 1'b1);
		random_phase();
		// Receiver idles less than the sender.
		drain_and_set(65, 32, 1'b1);
		random_phase();
		// Neither side idles: one byte per cycle.
		drain_and_set(0, 0, 1'b1);
		random_phase();

		// Wait for the last results, then let the clock run on so that a stray
		// extra result beat would still be caught.
		drain_and_set(0, 0, 1'b1);
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/updc_pkg.sv
design/url_path_percent_decode_check_top.sv
design/updc_checker.sv
sim/updc_decode_checker.sv
sim/url_path_percent_decode_check_top_tb.sv
